// File: rtl/kdeh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdeh_pkg: shared types and codes for the key debounce block
// Request payloads, per-key flag group, command and register codes.
// ----------------------------------------------------------------------------
package kdeh_pkg;

    localparam int RAW_W     = 4;   // raw key lines
    localparam int OUT_W     = 5;   // reported keys, bit 4 is any-key
    localparam int CNT_W     = 8;   // debounce and hold counters
    localparam int CFG_IDX_W = 1;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS     = 1'b1;

    localparam logic [CNT_W-1:0] CNT_MAX          = '1;
    localparam logic [CNT_W-1:0] DEBOUNCE_DEFAULT = 8'd2;
    localparam logic [CNT_W-1:0] HOLD_DEFAULT     = 8'd20;

    typedef struct packed {
        logic             cmd;
        logic [RAW_W-1:0] raw_keys;
    } t_in_item;

    typedef struct packed {
        logic [OUT_W-1:0] rising_bits;
        logic [OUT_W-1:0] falling_bits;
        logic [OUT_W-1:0] level_bits;
        logic [OUT_W-1:0] hold_bits;
    } t_out_item;

    typedef struct packed {
        logic rise;
        logic fall;
        logic level;
        logic hold;
    } t_key_flags;

endpackage

// File: rtl/key_debounce_edge_hold_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_debounce_edge_hold_top: key debounce with edge and hold detection
// Four raw key lines plus an any-key, qualified per tick, pulsed per evaluate.
// ----------------------------------------------------------------------------
// Takes one request per clock cycle while o_in_stall is low and returns
// exactly one result per request, in order. Every key's state is updated
// by a single level of logic at the accepting edge; the result lands in an
// output register backed by one skid entry, so a stall on the result side
// reaches o_in_stall only through a register and a stalled result does not
// stop the next request from entering. Registers may be written only while
// no request is outstanding; the write channel is always ready.
module key_debounce_edge_hold_top #(
    parameter int NUM_KEYS = 5
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  kdeh_pkg::t_in_item             i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output kdeh_pkg::t_out_item            o_out_item,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [kdeh_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [kdeh_pkg::CNT_W-1:0]     i_cfg_data
);

    logic [kdeh_pkg::CNT_W-1:0] r_debounce_ticks;
    logic [kdeh_pkg::CNT_W-1:0] r_hold_ticks;

    logic                 w_accept;
    kdeh_pkg::t_key_flags w_flags [NUM_KEYS];
    kdeh_pkg::t_out_item  w_result;

    logic                r_out_valid;
    kdeh_pkg::t_out_item r_out_item;
    logic                r_skid_valid;
    kdeh_pkg::t_out_item r_skid_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks <= kdeh_pkg::DEBOUNCE_DEFAULT;
            r_hold_ticks     <= kdeh_pkg::HOLD_DEFAULT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                kdeh_pkg::CFG_DEBOUNCE_TICKS: r_debounce_ticks <= i_cfg_data;
                kdeh_pkg::CFG_HOLD_TICKS:     r_hold_ticks     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_stall = r_skid_valid;
    assign w_accept   = i_in_valid & ~r_skid_valid;

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
        logic w_line;
        if (k < kdeh_pkg::RAW_W) begin : g_raw
            assign w_line = i_in_item.raw_keys[k];
        end else if (k == kdeh_pkg::RAW_W) begin : g_any
            assign w_line = |i_in_item.raw_keys;
        end else begin : g_none
            assign w_line = 1'b0;
        end

        kdeh_key u_key (
            .i_clk            (i_clk),
            .i_rst_n          (i_rst_n),
            .i_step           (w_accept),
            .i_cmd            (i_in_item.cmd),
            .i_line           (w_line),
            .i_debounce_ticks (r_debounce_ticks),
            .i_hold_ticks     (r_hold_ticks),
            .o_next           (w_flags[k])
        );
    end

    for (genvar b = 0; b < kdeh_pkg::OUT_W; b++) begin : g_bit
        if (b < NUM_KEYS) begin : g_used
            assign w_result.rising_bits[b]  = w_flags[b].rise;
            assign w_result.falling_bits[b] = w_flags[b].fall;
            assign w_result.level_bits[b]   = w_flags[b].level;
            assign w_result.hold_bits[b]    = w_flags[b].hold;
        end else begin : g_absent
            assign w_result.rising_bits[b]  = 1'b0;
            assign w_result.falling_bits[b] = 1'b0;
            assign w_result.level_bits[b]   = 1'b0;
            assign w_result.hold_bits[b]    = 1'b0;
        end
    end

    // output register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_accept;
            end
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_out_stall) begin
            if (r_skid_valid) begin
                r_out_item <= r_skid_item;
            end else if (w_accept) begin
                r_out_item <= w_result;
            end
        end else if (w_accept) begin
            r_skid_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_edges_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_item.rising_bits & o_out_item.falling_bits) == '0))
        else $error("press and release pulse on the same key");

    a_hold_needs_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_item.hold_bits & ~o_out_item.level_bits) == '0))
        else $error("hold flag without qualified level");

    a_press_before_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_item.rising_bits & o_out_item.level_bits) == '0))
        else $error("press pulse on a key already at level");

endmodule

// File: rtl/kdeh_key.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdeh_key: one key's debounce, edge and hold state
// Applies a tick or an evaluate step on each request and presents the
// flags as they stand after that request.
// ----------------------------------------------------------------------------
module kdeh_key (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic                       i_cmd,
    input  logic                       i_line,
    input  logic [kdeh_pkg::CNT_W-1:0] i_debounce_ticks,
    input  logic [kdeh_pkg::CNT_W-1:0] i_hold_ticks,
    output kdeh_pkg::t_key_flags       o_next
);

    logic [kdeh_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [kdeh_pkg::CNT_W-1:0] r_hcnt, n_hcnt;
    logic r_det, n_det;
    logic r_hold, n_hold;
    logic r_level, n_level;
    logic r_rise, n_rise;
    logic r_fall, n_fall;

    always_comb begin
        n_cnt   = r_cnt;
        n_hcnt  = r_hcnt;
        n_det   = r_det;
        n_hold  = r_hold;
        n_level = r_level;
        n_rise  = r_rise;
        n_fall  = r_fall;
        case (i_cmd)
            kdeh_pkg::CMD_TICK: begin
                if (i_line) begin
                    if (r_cnt > i_debounce_ticks) begin
                        n_det = 1'b1;
                    end else if (r_cnt != kdeh_pkg::CNT_MAX) begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end else begin
                    n_cnt = '0;
                    n_det = 1'b0;
                end
                // hold runs off the qualified level, not the raw line
                if (r_level) begin
                    if (r_hcnt > i_hold_ticks) begin
                        n_hold = 1'b1;
                    end else if (r_hcnt != kdeh_pkg::CNT_MAX) begin
                        n_hcnt = r_hcnt + 1'b1;
                    end
                end else begin
                    n_hcnt = '0;
                    n_hold = 1'b0;
                end
            end
            default: begin
                // last press pulse becomes the level, then make new pulses
                n_level = r_level | r_rise;
                n_rise  = r_det & ~n_level;
                n_fall  = 1'b0;
                if (!r_det && n_level) begin
                    n_fall  = 1'b1;
                    n_level = 1'b0;
                    n_hold  = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_hcnt  <= '0;
            r_det   <= 1'b0;
            r_hold  <= 1'b0;
            r_level <= 1'b0;
            r_rise  <= 1'b0;
            r_fall  <= 1'b0;
        end else if (i_step) begin
            r_cnt   <= n_cnt;
            r_hcnt  <= n_hcnt;
            r_det   <= n_det;
            r_hold  <= n_hold;
            r_level <= n_level;
            r_rise  <= n_rise;
            r_fall  <= n_fall;
        end
    end

    assign o_next.rise  = n_rise;
    assign o_next.fall  = n_fall;
    assign o_next.level = n_level;
    assign o_next.hold  = n_hold;

endmodule

// File: tb/tb_key_debounce_edge_hold_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_debounce_edge_hold_top: self-checking bench for the key debounce block
// Feeds ticks and evaluate steps under random idling on both sides. Every
// result is checked against a cycle-free model of the per-key counters,
// pulses, levels and hold flags. Threshold registers change between phases.
// ----------------------------------------------------------------------------
module tb_key_debounce_edge_hold_top;

    localparam int NK        = 5;
    localparam int LIMIT     = 300000;
    localparam int MAX_SHOWN = 10;

    logic                           i_clk;
    logic                           i_rst_n     = 1'b0;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_stall;
    kdeh_pkg::t_in_item             i_in_item   = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    kdeh_pkg::t_out_item            o_out_item;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [kdeh_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [kdeh_pkg::CNT_W-1:0]     i_cfg_data  = '0;

    key_debounce_edge_hold_top #(.NUM_KEYS(NK)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Key state as the block should hold it
    logic [kdeh_pkg::CNT_W-1:0] debounce_thr;
    logic [kdeh_pkg::CNT_W-1:0] hold_thr;
    logic [kdeh_pkg::CNT_W-1:0] db_cnt [NK];
    logic [kdeh_pkg::CNT_W-1:0] hd_cnt [NK];
    logic [NK-1:0]              detected, level, held, rise, fall;

    kdeh_pkg::t_in_item  pending_reqs [$];
    kdeh_pkg::t_out_item expected_flags [$];

    int cycle_cnt   = 0;
    int n_errors    = 0;
    int n_queued    = 0;
    int n_ticks     = 0;
    int n_evals     = 0;
    int n_results   = 0;
    int n_presses   = 0;
    int n_releases  = 0;
    int n_holds     = 0;
    int n_settings  = 1;

    // No idling in one recurring window of the run
    wire steady = (cycle_cnt % 3000) < 600;

    function automatic kdeh_pkg::t_out_item advance_keys(kdeh_pkg::t_in_item req);
        kdeh_pkg::t_out_item r;
        logic                line;
        for (int k = 0; k < NK; k++) begin
            if (req.cmd == kdeh_pkg::CMD_TICK) begin
                line = (k < kdeh_pkg::RAW_W) ? req.raw_keys[k]
                     : (k == kdeh_pkg::RAW_W) ? |req.raw_keys : 1'b0;
                if (line) begin
                    if (db_cnt[k] > debounce_thr) begin
                        detected[k] = 1'b1;
                    end else if (db_cnt[k] != kdeh_pkg::CNT_MAX) begin
                        db_cnt[k]++;
                    end
                end else begin
                    db_cnt[k]   = '0;
                    detected[k] = 1'b0;
                end
                if (level[k]) begin
                    if (hd_cnt[k] > hold_thr) begin
                        held[k] = 1'b1;
                    end else if (hd_cnt[k] != kdeh_pkg::CNT_MAX) begin
                        hd_cnt[k]++;
                    end
                end else begin
                    hd_cnt[k] = '0;
                    held[k]   = 1'b0;
                end
            end else begin
                // A pulse from the last evaluate turns into a steady level
                if (rise[k]) begin
                    rise[k]  = 1'b0;
                    level[k] = 1'b1;
                end
                fall[k] = 1'b0;
                if (detected[k] && !level[k]) begin
                    rise[k] = 1'b1;
                end
                if (!detected[k] && level[k]) begin
                    fall[k]  = 1'b1;
                    level[k] = 1'b0;
                    held[k]  = 1'b0;
                end
            end
        end
        r.rising_bits  = rise[kdeh_pkg::OUT_W-1:0];
        r.falling_bits = fall[kdeh_pkg::OUT_W-1:0];
        r.level_bits   = level[kdeh_pkg::OUT_W-1:0];
        r.hold_bits    = held[kdeh_pkg::OUT_W-1:0];
        return r;
    endfunction

    // Driver: hold the request while stalled, launch the next one otherwise
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_flags.push_back(advance_keys(i_in_item));
                if (i_in_item.cmd == kdeh_pkg::CMD_TICK) begin
                    n_ticks++;
                end else begin
                    n_evals++;
                end
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_reqs.size() != 0 && (steady || $urandom_range(99) >= 38)) begin
                    i_in_item  <= pending_reqs.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted result against the oldest prediction
    always @(posedge i_clk) begin
        kdeh_pkg::t_out_item want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                n_results++;
                if (expected_flags.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_SHOWN) begin
                        $display("unexpected result r=%b f=%b l=%b h=%b",
                                 o_out_item.rising_bits, o_out_item.falling_bits,
                                 o_out_item.level_bits, o_out_item.hold_bits);
                    end
                end else begin
                    want = expected_flags.pop_front();
                    if (o_out_item.rising_bits  !== want.rising_bits  ||
                        o_out_item.falling_bits !== want.falling_bits ||
                        o_out_item.level_bits   !== want.level_bits   ||
                        o_out_item.hold_bits    !== want.hold_bits) begin
                        n_errors++;
                        if (n_errors <= MAX_SHOWN) begin
                            $display("mismatch at result %0d: exp r=%b f=%b l=%b h=%b",
                                     n_results, want.rising_bits, want.falling_bits,
                                     want.level_bits, want.hold_bits);
                            $display("                       got r=%b f=%b l=%b h=%b",
                                     o_out_item.rising_bits, o_out_item.falling_bits,
                                     o_out_item.level_bits, o_out_item.hold_bits);
                        end
                    end
                    if (want.rising_bits != '0)  n_presses++;
                    if (want.falling_bits != '0) n_releases++;
                    if (want.hold_bits != '0)    n_holds++;
                end
            end
            i_out_stall <= steady ? 1'b0 : ($urandom_range(99) < 38);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT) begin
            $display("timeout after %0d cycles, %0d predictions outstanding",
                     cycle_cnt, expected_flags.size());
            $display("tb_key_debounce_edge_hold_top: done, errors");
            $finish;
        end
    end

    task automatic push_req(logic cmd, logic [kdeh_pkg::RAW_W-1:0] keys);
        kdeh_pkg::t_in_item r;
        r.cmd      = cmd;
        r.raw_keys = keys;
        pending_reqs.push_back(r);
        n_queued++;
    endtask

    // Steady key pattern over a run of ticks, with evaluate steps scattered in
    task automatic add_run(logic [kdeh_pkg::RAW_W-1:0] keys, int nticks, int eval_pct);
        for (int i = 0; i < nticks; i++) begin
            push_req(kdeh_pkg::CMD_TICK, keys);
            if ($urandom_range(99) < eval_pct) begin
                push_req(kdeh_pkg::CMD_EVAL, 4'($urandom_range(15)));
            end
        end
    endtask

    // Mostly steady runs around the thresholds, with bursts of bounce noise
    task automatic fill_random(int n_items);
        int stop_at;
        int len;
        int dt;
        int ht;
        stop_at = n_queued + n_items;
        dt = int'(debounce_thr);
        ht = int'(hold_thr);
        while (n_queued < stop_at) begin
            if ($urandom_range(99) < 25) begin
                len = int'($urandom_range(1, 8));
                repeat (len) push_req($urandom_range(1) ? kdeh_pkg::CMD_EVAL
                                                        : kdeh_pkg::CMD_TICK,
                                      4'($urandom_range(15)));
            end else begin
                len = ($urandom_range(3) == 0) ? int'($urandom_range(1, dt + ht + 12))
                                               : int'($urandom_range(1, dt + 4));
                add_run(4'($urandom_range(15)), len, int'($urandom_range(10, 60)));
            end
        end
    endtask

    // Wait until every request has been answered; sample between edges
    task automatic settle;
        while (pending_reqs.size() != 0 || i_in_valid || expected_flags.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [kdeh_pkg::CFG_IDX_W-1:0] idx,
                             logic [kdeh_pkg::CNT_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            kdeh_pkg::CFG_DEBOUNCE_TICKS: debounce_thr = data;
            kdeh_pkg::CFG_HOLD_TICKS:     hold_thr     = data;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_thresholds(logic [kdeh_pkg::CNT_W-1:0] dt,
                                  logic [kdeh_pkg::CNT_W-1:0] ht);
        write_reg(kdeh_pkg::CFG_DEBOUNCE_TICKS, dt);
        write_reg(kdeh_pkg::CFG_HOLD_TICKS, ht);
        n_settings++;
    endtask

    initial begin
        debounce_thr = kdeh_pkg::DEBOUNCE_DEFAULT;
        hold_thr     = kdeh_pkg::HOLD_DEFAULT;
        detected = '0;
        level    = '0;
        held     = '0;
        rise     = '0;
        fall     = '0;
        for (int k = 0; k < NK; k++) begin
            db_cnt[k] = '0;
            hd_cnt[k] = '0;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default thresholds: full press and release of all keys, keys ignored on
        // evaluate, then a bounce that drops single keys but keeps the any-key
        push_req(kdeh_pkg::CMD_EVAL, 4'hF);
        repeat (4) push_req(kdeh_pkg::CMD_TICK, 4'hF);
        push_req(kdeh_pkg::CMD_EVAL, 4'h0);
        push_req(kdeh_pkg::CMD_EVAL, 4'h0);
        push_req(kdeh_pkg::CMD_TICK, 4'h0);
        push_req(kdeh_pkg::CMD_EVAL, 4'hF);
        push_req(kdeh_pkg::CMD_EVAL, 4'h0);
        repeat (4) push_req(kdeh_pkg::CMD_TICK, 4'h5);
        push_req(kdeh_pkg::CMD_TICK, 4'hA);
        push_req(kdeh_pkg::CMD_EVAL, 4'h0);
        repeat (4) push_req(kdeh_pkg::CMD_TICK, 4'h8);
        push_req(kdeh_pkg::CMD_EVAL, 4'h0);
        push_req(kdeh_pkg::CMD_EVAL, 4'h0);
        push_req(kdeh_pkg::CMD_TICK, 4'h0);
        push_req(kdeh_pkg::CMD_EVAL, 4'h0);
        fill_random(400);
        settle;

        // Zero thresholds: detection and hold as fast as the counters allow
        set_thresholds('0, '0);
        fill_random(350);
        settle;

        // Top of the range: one long press reaches hold, release leaves the count
        set_thresholds(8'd254, 8'd254);
        add_run(4'h6, 620, 8);
        push_req(kdeh_pkg::CMD_EVAL, 4'h0);
        add_run(4'h0, 3, 30);
        fill_random(200);
        settle;

        set_thresholds(8'($urandom_range(1, 6)), 8'($urandom_range(0, 12)));
        fill_random(300);
        settle;
        repeat (8) @(posedge i_clk);

        $display("ran %0d ticks and %0d evaluate steps over %0d threshold settings",
                 n_ticks, n_evals, n_settings);
        $display("checked %0d results: %0d with presses, %0d with releases, %0d with holds",
                 n_results, n_presses, n_releases, n_holds);
        if (n_errors == 0 && expected_flags.size() == 0) begin
            $display("tb_key_debounce_edge_hold_top: done, clean");
        end else begin
            $display("%0d mismatches, %0d predictions left over", n_errors,
                     expected_flags.size());
            $display("tb_key_debounce_edge_hold_top: done, errors");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/kdeh_pkg.sv
rtl/kdeh_key.sv
rtl/key_debounce_edge_hold_top.sv
tb/tb_key_debounce_edge_hold_top.sv
